FILE: rtl/rwlpe_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the ROI-weighted luma PID exposure block.
// Used by the controller, the datapath and the top level.
package rwlpe_pkg;

   localparam int REQ_TDATA_W  = 56;
   localparam int RSP_TDATA_W  = 40;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 20;

   localparam int SUM_W        = 48;
   localparam int TOTAL_W      = 40;
   localparam int QUOT_W       = 17;
   localparam int ERR_W        = 18;
   localparam int EXPO_W       = 20;
   localparam int WEIGHT_W     = 24;

   localparam int INTEG_LIMIT  = 128000;
   localparam int RECIP_5      = 205;
   localparam int GAIN_FLOOR   = 40;

   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_LUMA  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPO_MIN     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPO_MAX     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_EXPO   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 3'd5;

   typedef struct packed {
      logic latch_roi;
      logic calc_dist;
      logic div_start;
      logic div_measure;
      logic mult_gain;
      logic calc_weight;
      logic accumulate;
      logic pid_err;
      logic pid_adj;
      logic finish;
   } rwlpe_cmd_type;

   typedef struct packed {
      logic frame_open;
      logic last;
      logic div_busy;
      logic out_free;
   } rwlpe_status_type;

endpackage

FILE: rtl/roi_weighted_luma_pid_exposure_top.sv
`timescale 1ns / 1ps
// Top level of the ROI-weighted luma PID exposure block.
// Depends on rwlpe_pkg, rwlpe_ctrl and rwlpe_datapath.
//
//  channel  dir  handshake           payload
//  req_     in   tvalid/tready       tdata pixel and ROI fields, tlast frame end
//  rsp_     out  tvalid/tready       tdata new exposure and measured luma
//  csr_     in   we                  index, wdata
//
// A pixel runs through the distance, the 17-step divider for the ROI proximity, the gain
// product, the weight and the accumulation; the first of a frame latches the ROI before that.
// The last pixel of a frame goes on to the mean-luma division and the PID step.
// Reset is synchronous and restores all settings.
// A result waiting on rsp_tready holds only the next frame end; pixels still flow.
module roi_weighted_luma_pid_exposure_top #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // gray level, roi_x_frac, roi_y_frac, roi_strength
   input  logic [rwlpe_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // new_exposure, measured_luma, zero pad
   output logic [rwlpe_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input  logic                               csr_we,
   input  logic [rwlpe_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [rwlpe_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import rwlpe_pkg::*;

   rwlpe_cmd_type    cmd;
   rwlpe_status_type status;

   rwlpe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rwlpe_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

FILE: rtl/rwlpe_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, 17 quotient bits.
// Depends on rwlpe_pkg.
module rwlpe_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [rwlpe_pkg::TOTAL_W-1:0]   rem_init,
   input  logic [rwlpe_pkg::QUOT_W-1:0]    low_bits,
   input  logic [rwlpe_pkg::TOTAL_W-1:0]   divisor,
   output logic                            busy,
   output logic [rwlpe_pkg::QUOT_W-1:0]    quotient
);
   import rwlpe_pkg::*;

   localparam int CNT_W = $clog2(QUOT_W + 1);

   logic [TOTAL_W-1:0] rem_ff, rem_in;
   logic [QUOT_W-1:0]  quo_ff, quo_in;
   logic [TOTAL_W-1:0] div_ff, div_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [TOTAL_W:0]   trial;
   logic               ge;

   always_comb begin
      trial  = {rem_ff, quo_ff[QUOT_W-1]};
      ge     = trial >= {1'b0, div_ff};
      rem_in = rem_ff;
      quo_in = quo_ff;
      div_in = div_ff;
      cnt_in = cnt_ff;
      if (start) begin
         rem_in = rem_init;
         quo_in = low_bits;
         div_in = divisor;
         cnt_in = CNT_W'(QUOT_W);
      end else if (cnt_ff != '0) begin
         rem_in = ge ? TOTAL_W'(trial - {1'b0, div_ff}) : trial[TOTAL_W-1:0];
         quo_in = {quo_ff[QUOT_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign busy     = cnt_ff != '0;
   assign quotient = quo_ff;

endmodule

FILE: rtl/rwlpe_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for one pixel and for the frame-end PID step.
// Depends on rwlpe_pkg; drives the datapath through command signals.
module rwlpe_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  rwlpe_pkg::rwlpe_status_type status,
   output rwlpe_pkg::rwlpe_cmd_type    cmd
);
   import rwlpe_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_LATCH, S_DIST, S_DIVP, S_WAITP, S_MULT, S_WEIGHT, S_ACCUM,
      S_DIVM, S_WAITM, S_PID1, S_PID2, S_DONE
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = status.frame_open ? S_DIST : S_LATCH;
         end
         S_LATCH: begin
            cmd.latch_roi = 1'b1;
            state_in      = S_DIST;
         end
         S_DIST: begin
            cmd.calc_dist = 1'b1;
            state_in      = S_DIVP;
         end
         S_DIVP: begin
            cmd.div_start = 1'b1;
            state_in      = S_WAITP;
         end
         S_WAITP: begin
            if (!status.div_busy) state_in = S_MULT;
         end
         S_MULT: begin
            cmd.mult_gain = 1'b1;
            state_in      = S_WEIGHT;
         end
         S_WEIGHT: begin
            cmd.calc_weight = 1'b1;
            state_in        = S_ACCUM;
         end
         S_ACCUM: begin
            cmd.accumulate = 1'b1;
            state_in       = status.last ? S_DIVM : S_IDLE;
         end
         S_DIVM: begin
            cmd.div_start   = 1'b1;
            cmd.div_measure = 1'b1;
            state_in        = S_WAITM;
         end
         S_WAITM: begin
            if (!status.div_busy) state_in = S_PID1;
         end
         S_PID1: begin
            cmd.pid_err = 1'b1;
            state_in    = S_PID2;
         end
         S_PID2: begin
            cmd.pid_adj = 1'b1;
            state_in    = S_DONE;
         end
         S_DONE: begin
            cmd.finish = status.out_free;
            if (status.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = state_ff == S_IDLE;

endmodule

FILE: rtl/rwlpe_datapath.sv
`timescale 1ns / 1ps
// Datapath: settings, pixel counters, ROI weight, accumulators, PID and output register.
// Depends on rwlpe_pkg and rwlpe_div.
module rwlpe_datapath #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   input  logic                                 req_tready,
   input  logic [rwlpe_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic                                 req_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [rwlpe_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input  logic                                 csr_we,
   input  logic [rwlpe_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rwlpe_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  rwlpe_pkg::rwlpe_cmd_type             cmd,
   output rwlpe_pkg::rwlpe_status_type          status
);
   import rwlpe_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int XW = $clog2(MAX_WIDTH + 1);
   localparam int YW = $clog2(MAX_HEIGHT + 1);
   localparam int DW = (XW > YW) ? XW : YW;
   localparam int NW = 2 * DW + 6;

   // settings
   logic [7:0]        target_ff;
   logic [EXPO_W-1:0] min_ff, max_ff, expo_ff;
   logic [8:0]        fw_ff, fh_ff;

   // captured request
   logic [7:0]  luma_ff;
   logic [15:0] rx_ff, ry_ff, rs_ff;
   logic        last_ff;

   // frame state
   logic [CW-1:0]      col_ff;
   logic [RW-1:0]      row_ff;
   logic [CW-1:0]      roi_col_ff;
   logic [RW-1:0]      roi_row_ff;
   logic [15:0]        gain_ff;
   logic               open_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic [TOTAL_W-1:0] total_ff;
   logic signed [ERR_W-1:0] integ_ff, prev_ff;

   // working registers
   logic [NW-1:0]       num_ff, dd_ff;
   logic [31:0]         prod_ff;
   logic [WEIGHT_W-1:0] weight_ff;
   logic [QUOT_W-1:0]   meas_ff;
   logic signed [21:0]  v_ff;
   logic signed [8:0]   adj_ff;

   logic               rsp_valid_ff;
   logic [EXPO_W-1:0]  rsp_expo_ff;
   logic [15:0]        rsp_meas_ff;

   logic [XW-1:0] w_eff;
   logic [YW-1:0] h_eff;
   logic [16+XW-1:0] roi_x_prod;
   logic [16+YW-1:0] roi_y_prod;
   logic signed [CW:0] dx;
   logic signed [RW:0] dy;
   logic signed [NW-1:0] d2, dd, num;
   logic [34:0]        prod5;
   logic [31:0]        luma_w;
   logic [SUM_W:0]     sum_next;
   logic [TOTAL_W:0]   total_next;
   logic signed [18:0] err;
   logic signed [19:0] isum;
   logic signed [ERR_W-1:0] integ_new;
   logic signed [21:0] e22, p22, i22, vsum;
   logic [21:0]        mag;
   logic [17:0]        recip_prod;
   logic [7:0]         quot5;
   logic signed [21:0] nx;
   logic [EXPO_W-1:0]  expo_next;
   logic               out_free;

   logic               div_busy;
   logic [QUOT_W-1:0]  div_quot;
   logic [TOTAL_W-1:0] div_rem_init, div_divisor;
   logic [QUOT_W-1:0]  div_low;

   always_comb begin
      if (fw_ff == '0) w_eff = XW'(1);
      else if (32'(fw_ff) > MAX_WIDTH) w_eff = XW'(MAX_WIDTH);
      else w_eff = XW'(fw_ff);
      if (fh_ff == '0) h_eff = YW'(1);
      else if (32'(fh_ff) > MAX_HEIGHT) h_eff = YW'(MAX_HEIGHT);
      else h_eff = YW'(fh_ff);

      roi_x_prod = (16+XW)'(rx_ff) * (16+XW)'(w_eff);
      roi_y_prod = (16+YW)'(ry_ff) * (16+YW)'(h_eff);

      dx  = $signed({1'b0, col_ff}) - $signed({1'b0, roi_col_ff});
      dy  = $signed({1'b0, row_ff}) - $signed({1'b0, roi_row_ff});
      d2  = NW'(dx) * NW'(dx) + NW'(dy) * NW'(dy);
      dd  = $signed(NW'(w_eff) * NW'(w_eff) + NW'(h_eff) * NW'(h_eff));
      num = dd - ((d2 <<< 3) + (d2 <<< 1));

      prod5      = (35'(prod_ff) << 2) + 35'(prod_ff);
      luma_w     = 32'(luma_ff) * 32'(weight_ff);
      sum_next   = {1'b0, sum_ff} + (SUM_W+1)'(luma_w);
      total_next = {1'b0, total_ff} + (TOTAL_W+1)'(weight_ff);

      err  = $signed({3'b0, target_ff, 8'b0}) - $signed({2'b0, div_quot});
      isum = $signed({{2{integ_ff[ERR_W-1]}}, integ_ff}) + $signed({err[18], err});
      if (isum > $signed(20'(INTEG_LIMIT))) integ_new = ERR_W'(INTEG_LIMIT);
      else if (isum < -$signed(20'(INTEG_LIMIT))) integ_new = -ERR_W'(INTEG_LIMIT);
      else integ_new = ERR_W'(isum);
      e22  = 22'(err);
      p22  = 22'(prev_ff);
      i22  = 22'(integ_new);
      vsum = (e22 <<< 3) + (e22 <<< 1) + e22 - (p22 <<< 1) + i22;

      mag        = v_ff[21] ? 22'(-v_ff) : v_ff;
      recip_prod = 18'(mag[19:10]) * 18'(RECIP_5);
      quot5      = recip_prod[17:10];

      nx = $signed({2'b0, expo_ff}) + 22'(adj_ff);
      if (nx < $signed({2'b0, min_ff})) nx = $signed({2'b0, min_ff});
      if (nx > $signed({2'b0, max_ff})) nx = $signed({2'b0, max_ff});
      expo_next = nx[EXPO_W-1:0];

      if (cmd.div_measure) begin
         div_rem_init = TOTAL_W'(sum_ff[SUM_W-1:9]);
         div_low      = {sum_ff[8:0], 8'b0};
         div_divisor  = total_ff;
      end else begin
         div_rem_init = TOTAL_W'(num_ff >> 1);
         div_low      = {num_ff[0], 16'b0};
         div_divisor  = TOTAL_W'(dd_ff);
      end
      out_free = !rsp_valid_ff || rsp_tready;
   end

   rwlpe_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .rem_init (div_rem_init),
      .low_bits (div_low),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff    <= 8'd128;
         min_ff       <= EXPO_W'(1);
         max_ff       <= '1;
         expo_ff      <= EXPO_W'(1000);
         fw_ff        <= 9'd240;
         fh_ff        <= 9'd135;
         col_ff       <= '0;
         row_ff       <= '0;
         roi_col_ff   <= '0;
         roi_row_ff   <= '0;
         gain_ff      <= '0;
         open_ff      <= 1'b0;
         sum_ff       <= '0;
         total_ff     <= '0;
         integ_ff     <= '0;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_TARGET_LUMA:  target_ff <= csr_wdata[7:0];
               CSR_EXPO_MIN:     min_ff    <= csr_wdata;
               CSR_EXPO_MAX:     max_ff    <= csr_wdata;
               CSR_START_EXPO:   expo_ff   <= csr_wdata;
               CSR_FRAME_WIDTH:  fw_ff     <= csr_wdata[8:0];
               CSR_FRAME_HEIGHT: fh_ff     <= csr_wdata[8:0];
               default: ;
            endcase
         end
         if (cmd.latch_roi) begin
            roi_col_ff <= roi_x_prod[16+CW-1:16];
            roi_row_ff <= roi_y_prod[16+RW-1:16];
            gain_ff    <= rs_ff;
            open_ff    <= 1'b1;
         end
         if (cmd.accumulate) begin
            sum_ff   <= sum_next[SUM_W] ? '1 : sum_next[SUM_W-1:0];
            total_ff <= total_next[TOTAL_W] ? '1 : total_next[TOTAL_W-1:0];
            if ((XW+1)'(col_ff) + 1'b1 >= (XW+1)'(w_eff)) begin
               col_ff <= '0;
               row_ff <= ((YW+1)'(row_ff) + 1'b1 >= (YW+1)'(h_eff)) ? '0 : row_ff + 1'b1;
            end else begin
               col_ff <= col_ff + 1'b1;
            end
         end
         if (cmd.pid_err) begin
            integ_ff <= integ_new;
            prev_ff  <= ERR_W'(err);
         end
         if (cmd.finish || (rsp_valid_ff && rsp_tready)) rsp_valid_ff <= cmd.finish;
         if (cmd.finish) begin
            expo_ff      <= expo_next;
            col_ff       <= '0;
            row_ff       <= '0;
            sum_ff       <= '0;
            total_ff     <= '0;
            open_ff      <= 1'b0;
         end
      end
      if (req_tvalid && req_tready) begin
         luma_ff <= req_tdata[7:0];
         rx_ff   <= req_tdata[23:8];
         ry_ff   <= req_tdata[39:24];
         rs_ff   <= req_tdata[55:40];
         last_ff <= req_tlast;
      end
      if (cmd.calc_dist) begin
         dd_ff  <= dd;
         num_ff <= (num > 0) ? num : '0;
      end
      if (cmd.mult_gain) prod_ff <= 32'(gain_ff) * 32'(div_quot);
      if (cmd.calc_weight) begin
         weight_ff <= (32'(gain_ff) > GAIN_FLOOR)
                      ? WEIGHT_W'(24'h010000 + 24'(prod5[34:12])) : WEIGHT_W'(24'h010000);
      end
      if (cmd.pid_err) begin
         meas_ff <= div_quot;
         v_ff    <= vsum;
      end
      if (cmd.pid_adj) adj_ff <= v_ff[21] ? -$signed({1'b0, quot5}) : $signed({1'b0, quot5});
      if (cmd.finish) begin
         rsp_expo_ff <= expo_next;
         rsp_meas_ff <= meas_ff[15:0];
      end
   end

   assign status.frame_open = open_ff;
   assign status.last       = last_ff;
   assign status.div_busy   = div_busy;
   assign status.out_free   = out_free;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_meas_ff, rsp_expo_ff};

`ifndef SYNTHESIS
   a_expo_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_expo_ff <= max_ff)
      else $error("exposure above maximum");
   a_total_nonzero: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_start && cmd.div_measure) |-> total_ff != '0)
      else $error("mean taken over empty frame");
   a_frame_closed: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> !open_ff && sum_ff == '0)
      else $error("frame state not cleared with result");
`endif

endmodule
